// ----- rtl/lkrc_pkg.sv -----
// lkrc_pkg: shared constants, types and key folding for the lru keyed record cache
// used by lkrc_ctrl, lkrc_dp, lru_keyed_record_cache, lkrc_lookup_checker and tb_top; depends on nothing
package lkrc_pkg;

    // geometry
    localparam int CAPACITY      = 16;
    localparam int KEY_CHARS     = 8;
    localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int REC_W         = IDX_W;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);

    // field widths
    localparam int CMD_W         = 2;
    localparam int KEY_W         = 64;
    localparam int PRICE_W       = 48;
    localparam int STAMP_W       = 32;
    localparam int ENTRY_COUNT_W = 5;

    // stream payload widths
    localparam int IN_TDATA_W    = KEY_W + PRICE_W + STAMP_W;
    localparam int OUT_FIELDS_W  = 1 + PRICE_W + STAMP_W + ENTRY_COUNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TOUCH  = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_UPDATE = 2'd2
    } t_cmd;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_blocked;
    } t_dp_status;

    // fold A to Z to lower case and drop everything from the first zero byte
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        logic [7:0]       b;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < 8; i++) begin
            b = k[KEY_W-1-8*i -: 8];
            if (b == 8'h00 || i >= KEY_CHARS) begin
                live = 1'b0;
            end
            if (live) begin
                if (b >= 8'h41 && b <= 8'h5A) begin
                    b = b + 8'h20;
                end
                r[KEY_W-1-8*i -: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/lru_keyed_record_cache.sv -----
// lru_keyed_record_cache: fully associative record cache with lru replacement
// each taken beat is captured, then executed into the result register when that is not blocked
// by an untaken result; no new beat is taken until then. execution is a parallel key compare
// and recency update on the slot register file; a result left untaken holds the next beat
// reset: synchronous active-low i_rst_n empties all slots and clears the result valid
// depends on lkrc_pkg, lkrc_ctrl and lkrc_dp
module lru_keyed_record_cache (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // key [63:0], price [111:64], stamp [143:112]
    input  logic [lkrc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // cmd [1:0]
    input  logic [lkrc_pkg::CMD_W-1:0]          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // status [0], found_price [48:1], found_stamp [80:49], entry_count [85:81], zero [87:86]
    output logic [lkrc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    lkrc_pkg::t_ctrl_cmd                 cmd;
    lkrc_pkg::t_dp_status                status;
    logic                                out_status;
    logic [lkrc_pkg::PRICE_W-1:0]        out_price;
    logic [lkrc_pkg::STAMP_W-1:0]        out_stamp;
    logic [lkrc_pkg::ENTRY_COUNT_W-1:0]  out_count;

    // sequencer
    lkrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // slots and result register
    lkrc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_cmd     (i_s_axis_tuser),
        .i_in_key     (i_s_axis_tdata[lkrc_pkg::KEY_W-1:0]),
        .i_in_price   (i_s_axis_tdata[lkrc_pkg::KEY_W +: lkrc_pkg::PRICE_W]),
        .i_in_stamp   (i_s_axis_tdata[lkrc_pkg::KEY_W+lkrc_pkg::PRICE_W +: lkrc_pkg::STAMP_W]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_status (out_status),
        .o_out_price  (out_price),
        .o_out_stamp  (out_stamp),
        .o_out_count  (out_count)
    );

    // pack result beat
    assign o_m_axis_tdata = lkrc_pkg::OUT_TDATA_W'({out_count, out_stamp, out_price, out_status});

endmodule

// ----- rtl/lkrc_ctrl.sv -----
// lkrc_ctrl: two-state sequencer, capture of a beat then an execute state held while the result is blocked
// depends on lkrc_pkg
module lkrc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  lkrc_pkg::t_dp_status  i_status,
    output lkrc_pkg::t_ctrl_cmd   o_cmd
);

    lkrc_pkg::t_state r_state;
    lkrc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkrc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            lkrc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lkrc_pkg::S_EXEC;
                end
            end
            lkrc_pkg::S_EXEC: begin
                if (!i_status.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = lkrc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lkrc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lkrc_dp.sv -----
// lkrc_dp: slot register file, parallel key compare, recency update and result register
// depends on lkrc_pkg
module lkrc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lkrc_pkg::t_ctrl_cmd                i_cmd,
    output lkrc_pkg::t_dp_status               o_status,
    input  logic [lkrc_pkg::CMD_W-1:0]         i_in_cmd,
    input  logic [lkrc_pkg::KEY_W-1:0]         i_in_key,
    input  logic [lkrc_pkg::PRICE_W-1:0]       i_in_price,
    input  logic [lkrc_pkg::STAMP_W-1:0]       i_in_stamp,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_out_status,
    output logic [lkrc_pkg::PRICE_W-1:0]       o_out_price,
    output logic [lkrc_pkg::STAMP_W-1:0]       o_out_stamp,
    output logic [lkrc_pkg::ENTRY_COUNT_W-1:0] o_out_count
);

    localparam int N = lkrc_pkg::CAPACITY;

    // slot storage
    logic                           r_valid [N];
    logic [lkrc_pkg::REC_W-1:0]     r_rec   [N];
    logic [lkrc_pkg::KEY_W-1:0]     r_key   [N];
    logic [lkrc_pkg::PRICE_W-1:0]   r_price [N];
    logic [lkrc_pkg::STAMP_W-1:0]   r_stamp [N];
    logic [lkrc_pkg::COUNT_W-1:0]   r_total;

    // captured beat
    lkrc_pkg::t_cmd                 r_in_cmd;
    logic [lkrc_pkg::KEY_W-1:0]     r_in_key;
    logic [lkrc_pkg::PRICE_W-1:0]   r_in_price;
    logic [lkrc_pkg::STAMP_W-1:0]   r_in_stamp;

    // result register
    logic                           r_out_valid;
    logic                           r_out_status;
    logic [lkrc_pkg::PRICE_W-1:0]   r_out_price;
    logic [lkrc_pkg::STAMP_W-1:0]   r_out_stamp;
    logic [lkrc_pkg::COUNT_W-1:0]   r_out_count;

    // lookup results
    logic                           hit;
    logic [lkrc_pkg::IDX_W-1:0]     hit_idx;
    logic [lkrc_pkg::IDX_W-1:0]     free_idx;
    logic [lkrc_pkg::IDX_W-1:0]     lru_idx;
    logic [lkrc_pkg::IDX_W-1:0]     sel_idx;
    logic [lkrc_pkg::REC_W-1:0]     limit;
    logic                           full;
    logic                           insert;

    // parallel compare and lowest-index picks
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_valid[i] && r_key[i] == r_in_key) begin
                hit     = 1'b1;
                hit_idx = lkrc_pkg::IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = lkrc_pkg::IDX_W'(i);
            end
            if (r_valid[i] && r_rec[i] == lkrc_pkg::REC_W'(N - 1)) begin
                lru_idx = lkrc_pkg::IDX_W'(i);
            end
        end
        full    = (r_total == lkrc_pkg::COUNT_W'(N));
        insert  = !hit && !full;
        sel_idx = hit ? hit_idx : (full ? lru_idx : free_idx);
        limit   = hit ? r_rec[hit_idx] : r_rec[lru_idx];
    end

    // control state: valid bits, recency, count, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_valid[i] <= 1'b0;
                r_rec[i]   <= '0;
            end
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec && r_in_cmd == lkrc_pkg::CMD_TOUCH) begin
                for (int i = 0; i < N; i++) begin
                    if (lkrc_pkg::IDX_W'(i) == sel_idx) begin
                        r_rec[i] <= '0;
                    end else if (r_valid[i] && (insert || r_rec[i] < limit)) begin
                        r_rec[i] <= r_rec[i] + lkrc_pkg::REC_W'(1);
                    end
                end
                if (insert) begin
                    r_valid[sel_idx] <= 1'b1;
                    r_total          <= r_total + lkrc_pkg::COUNT_W'(1);
                end
            end
        end
    end

    // payload: captured beat, slot records, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_cmd   <= lkrc_pkg::t_cmd'(i_in_cmd);
            r_in_key   <= lkrc_pkg::norm_key(i_in_key);
            r_in_price <= i_in_price;
            r_in_stamp <= i_in_stamp;
        end
        if (i_cmd.exec) begin
            r_out_status <= 1'b0;
            r_out_price  <= '0;
            r_out_stamp  <= '0;
            r_out_count  <= r_total;
            unique case (r_in_cmd)
                lkrc_pkg::CMD_TOUCH: begin
                    r_key[sel_idx]   <= r_in_key;
                    r_price[sel_idx] <= r_in_price;
                    r_stamp[sel_idx] <= r_in_stamp;
                    if (insert) begin
                        r_out_count <= r_total + lkrc_pkg::COUNT_W'(1);
                    end
                end
                lkrc_pkg::CMD_SEARCH: begin
                    r_out_status <= !hit;
                    if (hit) begin
                        r_out_price <= r_price[hit_idx];
                        r_out_stamp <= r_stamp[hit_idx];
                    end
                end
                lkrc_pkg::CMD_UPDATE: begin
                    r_out_status <= !hit;
                    if (hit) begin
                        r_price[hit_idx] <= r_in_price;
                        r_stamp[hit_idx] <= r_in_stamp;
                    end
                end
                default: begin
                    r_out_status <= 1'b0;
                end
            endcase
        end
    end

    assign o_status.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_out_status         = r_out_status;
    assign o_out_price          = r_out_price;
    assign o_out_stamp          = r_out_stamp;
    assign o_out_count          = lkrc_pkg::ENTRY_COUNT_W'(r_out_count);

endmodule

// ----- dv/lkrc_lookup_checker.sv -----
// lkrc_lookup_checker: watches both stream channels of the lru keyed record cache,
// predicts each result from its own copy of the slots and compares it with the output
// depends on lkrc_pkg for widths and command codes
module lkrc_lookup_checker
    import lkrc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // key [63:0], price [111:64], stamp [143:112]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // cmd [1:0]
    input  logic [CMD_W-1:0]       i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // status [0], found_price [48:1], found_stamp [80:49], entry_count [85:81]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    output int                     o_pending,
    output int                     o_error_count
);

    typedef struct packed {
        logic                     status;
        logic [PRICE_W-1:0]       price;
        logic [STAMP_W-1:0]       stamp;
        logic [ENTRY_COUNT_W-1:0] count;
    } t_lookup_result;

    // shadow copy of the slot file
    logic               slot_used [CAPACITY];
    logic [KEY_W-1:0]   slot_sym  [CAPACITY];
    logic [PRICE_W-1:0] slot_px   [CAPACITY];
    logic [STAMP_W-1:0] slot_ts   [CAPACITY];
    int unsigned        slot_age  [CAPACITY];
    int unsigned        used_total;

    t_lookup_result expected_lookups [$];
    t_lookup_result got;
    t_lookup_result want;
    int             errors = 0;

    // case-folded symbol, cut at the first zero byte and at the key length
    function automatic logic [KEY_W-1:0] fold_symbol(input logic [KEY_W-1:0] sym);
        logic [KEY_W-1:0] r;
        logic [7:0]       b;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            b = sym[KEY_W-1-8*i -: 8];
            if (b == 8'h00 || i >= KEY_CHARS) break;
            if (b >= 8'h41 && b <= 8'h5A) b = b + 8'h20;
            r[KEY_W-1-8*i -: 8] = b;
        end
        return r;
    endfunction

    // apply one command to the shadow slots and return the answer it gives
    function automatic t_lookup_result predict_lookup(input logic [CMD_W-1:0] op,
            input logic [KEY_W-1:0] sym, input logic [PRICE_W-1:0] px,
            input logic [STAMP_W-1:0] ts);
        t_lookup_result r;
        int             hit;
        int             victim;
        int unsigned    bound;
        logic [KEY_W-1:0] probe;
        r     = '0;
        hit   = -1;
        probe = fold_symbol(sym);
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit < 0 && slot_used[i] && fold_symbol(slot_sym[i]) == probe) hit = i;
        end
        case (op)
            CMD_TOUCH: begin
                if (hit >= 0) begin
                    victim = hit;
                    bound  = slot_age[hit];
                end else if (used_total >= CAPACITY) begin
                    // evict the oldest, lowest index on a tie
                    victim = 0;
                    bound  = 0;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_used[i] && slot_age[i] > bound) begin
                            bound  = slot_age[i];
                            victim = i;
                        end
                    end
                end else begin
                    victim = -1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (victim < 0 && !slot_used[i]) victim = i;
                    end
                    slot_used[victim] = 1'b1;
                    used_total++;
                    bound = 32'hFFFF_FFFF;
                end
                // age the slots newer than the touched one
                for (int i = 0; i < CAPACITY; i++) begin
                    if (slot_used[i] && i != victim && slot_age[i] < bound) slot_age[i]++;
                end
                slot_age[victim] = 0;
                slot_sym[victim] = sym;
                slot_px[victim]  = px;
                slot_ts[victim]  = ts;
            end
            CMD_SEARCH: begin
                if (hit >= 0) begin
                    r.price = slot_px[hit];
                    r.stamp = slot_ts[hit];
                end else begin
                    r.status = 1'b1;
                end
            end
            CMD_UPDATE: begin
                if (hit >= 0) begin
                    slot_px[hit] = px;
                    slot_ts[hit] = ts;
                end else begin
                    r.status = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = used_total[ENTRY_COUNT_W-1:0];
        return r;
    endfunction

    // result beats are checked before the input beat of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
            end
            used_total = 0;
            expected_lookups.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tdata[0];
                got.price  = i_m_tdata[PRICE_W:1];
                got.stamp  = i_m_tdata[PRICE_W+STAMP_W:PRICE_W+1];
                got.count  = i_m_tdata[PRICE_W+STAMP_W+ENTRY_COUNT_W:PRICE_W+STAMP_W+1];
                if (expected_lookups.size() == 0) begin
                    if (errors < 10) begin
                        $display("result beat with nothing expected: %h", i_m_tdata);
                    end
                    errors++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (got !== want) begin
                        if (errors < 10) begin
                            $display("result mismatch (exp/act): status %0d/%0d price %h/%h",
                                want.status, got.status, want.price, got.price);
                            $display("  stamp %h/%h count %0d/%0d",
                                want.stamp, got.stamp, want.count, got.count);
                        end
                        errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_lookups.push_back(predict_lookup(i_s_tuser,
                    i_s_tdata[KEY_W-1:0],
                    i_s_tdata[KEY_W+PRICE_W-1:KEY_W],
                    i_s_tdata[IN_TDATA_W-1:KEY_W+PRICE_W]));
            end
        end
        o_pending     <= expected_lookups.size();
        o_error_count <= errors;
    end

endmodule

// ----- dv/tb_top.sv -----
// tb_top: drives command beats into the lru keyed record cache and stalls its results
// at random; prediction and comparison sit in lkrc_lookup_checker
// depends on lkrc_pkg, lru_keyed_record_cache and lkrc_lookup_checker
module tb_top;
    import lkrc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int POOL         = 24;
    localparam int RANDOM_ITEMS = 630;
    localparam int STALL_LIMIT  = 1000;

    logic                   clk     = 1'b0;
    logic                   rst_n   = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    logic [CMD_W-1:0]       s_user  = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    int                     pending;
    int                     error_count;

    // symbol pool for well-formed traffic
    logic [7:0] pool_chars [POOL][8];
    int         pool_len   [POOL];

    int tx_run   = 0;
    bit tx_burst = 1'b0;
    int rx_run   = 0;
    bit rx_burst = 1'b0;
    int rx_wait  = 0;
    int stall_cycles = 0;

    always #1 clk = ~clk;

    lru_keyed_record_cache i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    lkrc_lookup_checker i_cache_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_s_tuser     (s_user),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .o_pending     (pending),
        .o_error_count (error_count)
    );

    // result side: random stall after each beat, with runs of no stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else if (m_valid && m_ready) begin
            if (rx_run == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
                rx_run   = $urandom_range(10, 60);
            end else begin
                rx_run--;
            end
            rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
            m_ready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one command beat, after a random gap; returns at the edge it is taken
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] sym,
            input logic [PRICE_W-1:0] px, input logic [STAMP_W-1:0] ts);
        int gap;
        if (tx_run == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            tx_run   = $urandom_range(10, 60);
        end else begin
            tx_run--;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {ts, px, sym};
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
    endtask

    // hold the sender until every result has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // pool symbol with random letter case and junk after the terminator
    function automatic logic [KEY_W-1:0] make_symbol(input int p);
        logic [KEY_W-1:0] sym;
        logic [7:0]       b;
        for (int i = 0; i < 8; i++) begin
            if (i < pool_len[p]) begin
                b = pool_chars[p][i];
                if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
                        && $urandom_range(0, 1)) begin
                    b = b ^ 8'h20;
                end
            end else if (i == pool_len[p]) begin
                b = 8'h00;
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            sym[KEY_W-1-8*i -: 8] = b;
        end
        return sym;
    endfunction

    function automatic logic [PRICE_W-1:0] draw_price();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return w[PRICE_W-1:0];
        endcase
    endfunction

    function automatic logic [STAMP_W-1:0] draw_stamp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int               span;
        int               pick;
        int               kind;
        logic [CMD_W-1:0] op;
        logic [KEY_W-1:0] sym;

        // build the symbol pool: letters, digits, odd bytes and case-fold boundaries
        for (int p = 0; p < POOL; p++) begin
            pool_len[p] = $urandom_range(1, 8);
            for (int i = 0; i < 8; i++) begin
                kind = $urandom_range(0, 9);
                if (kind < 6)      pool_chars[p][i] = 8'(8'h61 + $urandom_range(0, 25));
                else if (kind < 8) pool_chars[p][i] = 8'(8'h30 + $urandom_range(0, 9));
                else if (kind < 9) pool_chars[p][i] = 8'($urandom_range(1, 255));
                else begin
                    case ($urandom_range(0, 3))
                        0:       pool_chars[p][i] = 8'h40;
                        1:       pool_chars[p][i] = 8'h5B;
                        2:       pool_chars[p][i] = 8'h60;
                        default: pool_chars[p][i] = 8'h7B;
                    endcase
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cache misses
        send_command(CMD_SEARCH, 64'h0, '0, '0);
        send_command(CMD_UPDATE, 64'h6162_6300_0000_0000, '1, '1);
        // empty symbol, and a key whose first byte is zero matching it
        send_command(CMD_TOUCH,  64'h0, '1, '1);
        send_command(CMD_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, '0, '0);
        // case folding over a full eight characters
        send_command(CMD_TOUCH,  64'h4142_4344_4546_4748, '0, '0);
        send_command(CMD_SEARCH, 64'h6162_6364_6566_6768, '1, '1);
        send_command(CMD_UPDATE, 64'h6142_6344_6546_6748, '1, 32'h8000_0001);
        send_command(CMD_SEARCH, 64'h4142_4344_4546_4748, '0, '0);
        // all-ones key: no terminator, no letters
        send_command(CMD_TOUCH,  64'hFFFF_FFFF_FFFF_FFFF, 48'h8000_0000_0001, '0);
        send_command(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        // bytes just outside the letter range are not folded, while Z at its edge is
        send_command(CMD_TOUCH,  64'h4000_0000_0000_0000, 48'h1, 32'h1);
        send_command(CMD_SEARCH, 64'h6000_0000_0000_0000, '0, '0);
        send_command(CMD_TOUCH,  64'h5B00_0000_0000_0000, 48'h2, 32'h2);
        send_command(CMD_SEARCH, 64'h7B00_0000_0000_0000, '0, '0);
        send_command(CMD_TOUCH,  64'h5A00_0000_0000_0000, 48'h3, 32'h3);
        send_command(CMD_SEARCH, 64'h7A00_0000_0000_0000, '0, '0);
        // unused command code
        send_command(CMD_SPARE,  64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
        // refresh of an existing symbol, then an update of the all-ones key and a search of the empty key
        send_command(CMD_TOUCH,  64'h6162_6364_6566_6768, 48'h1234_5678_9ABC, 32'hDEAD_BEEF);
        send_command(CMD_SEARCH, 64'h4162_4364_4566_4768, '0, '0);
        send_command(CMD_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
        send_command(CMD_SEARCH, 64'h0000_0000_0000_00FF, '0, '0);

        // random: mostly pool symbols, a working set that sometimes exceeds the capacity
        span = POOL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 80 == 0) span = $urandom_range(6, POOL);
            if (n % 200 == 100) wait_for_drain();
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                sym = {$urandom, $urandom};
                op  = CMD_W'($urandom_range(0, 3));
            end else begin
                sym = make_symbol($urandom_range(0, span - 1));
                if (pick < 45)      op = CMD_TOUCH;
                else if (pick < 75) op = CMD_SEARCH;
                else if (pick < 94) op = CMD_UPDATE;
                else                op = CMD_SPARE;
            end
            send_command(op, sym, draw_price(), draw_stamp());
        end

        // drain and settle
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
